### hw/rtl/glzw_pkg.sv
// Package for the GIF LZW pixel decoder: controller states, status codes,
// configuration register indexes and interlace pass tables. No dependencies.
package glzw_pkg;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StCheck = 6'b000010,
    StPop   = 6'b000100,
    StFirst = 6'b001000,
    StWalk  = 6'b010000,
    StWalkD = 6'b100000
  } state_e;

  localparam logic [1:0] StatusPixel   = 2'd0;
  localparam logic [1:0] StatusNeed    = 2'd1;
  localparam logic [1:0] StatusEnded   = 2'd2;
  localparam logic [1:0] StatusInvalid = 2'd3;

  localparam logic [1:0] RegMinCode    = 2'd0;
  localparam logic [1:0] RegWidth      = 2'd1;
  localparam logic [1:0] RegHeight     = 2'd2;
  localparam logic [1:0] RegInterlaced = 2'd3;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  function automatic logic [3:0] pass_step(input logic [1:0] p);
    case (p)
      2'd0, 2'd1: pass_step = 4'd8;
      2'd2:       pass_step = 4'd4;
      default:    pass_step = 4'd2;
    endcase
  endfunction

  function automatic logic [2:0] pass_start(input logic [1:0] p);
    case (p)
      2'd0:    pass_start = 3'd0;
      2'd1:    pass_start = 3'd4;
      2'd2:    pass_start = 3'd2;
      default: pass_start = 3'd1;
    endcase
  endfunction

endpackage

### hw/rtl/gif_lzw_pixel_decoder_unit.sv
// GIF LZW pixel decoder: sub-block stripping, code unpacking, dictionary and
// string stack in synchronous memories, pixel position tracking.
// Depends on glzw_pkg.
//
//  Channel   Direction  Transaction content
//  s_axis    in         tuser: command; tdata: data byte
//  m_axis    out        tuser: status; tdata: pixel index, x, y
//  cfg       in         cfg_addr_i: register index; cfg_data_i: value
//
// An emit tick that pops a stored pixel is accepted, reads the stack and then
// outputs the pixel; one that only answers a status skips the stack read. A code
// that needs decoding walks its string one character per chain step, each step
// waiting for a dictionary read. Reset is asynchronous and needs no clearing pass.
// A tick waits while the output register is still full, and no transaction is
// accepted until its result is in place.
module gif_lzw_pixel_decoder_unit #(
  parameter int DICT_DEPTH    = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] pixel_index, [23:8] pixel_x, [39:24] pixel_y
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  localparam int AW = $clog2(DICT_DEPTH);
  localparam int NW = AW + 1;
  localparam int CW = MAX_CODE_BITS;
  localparam int WW = (NW > CW + 1) ? NW : CW + 1;

  typedef struct packed {
    logic [AW-1:0] prefix;
    logic [7:0]    suffix;
    logic [7:0]    first;
  } entry_t;

  glzw_pkg::state_e state_q, state_d;

  logic [3:0]    min_q, min_d;
  logic [15:0]   wid_q, wid_d, hgt_q, hgt_d;
  logic          ilace_q, ilace_d;
  logic [3:0]    cw_q, cw_d;
  logic [NW-1:0] nfc_q, nfc_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] prev_q, prev_d;
  logic [7:0]    pfirst_q, pfirst_d;
  logic [CW-1:0] code_q, code_d;
  logic [AW-1:0] walk_q, walk_d;
  logic [NW-1:0] scnt_q, scnt_d;
  logic [23:0]   buf_q, buf_d;
  logic [4:0]    bcnt_q, bcnt_d;
  logic [7:0]    bbl_q, bbl_d;
  logic [15:0]   col_q, col_d, row_q, row_d;
  logic          ended_q, ended_d;
  logic          ovalid_q, ovalid_d;
  logic [1:0]    ostat_q, ostat_d;
  logic [39:0]   odata_q, odata_d;

  entry_t        dict_mem [DICT_DEPTH];
  logic [7:0]    stack_mem [DICT_DEPTH];
  logic          dwe, dre, swe, sre;
  logic [AW-1:0] dwa, dra, swa, sra;
  entry_t        dwd, drd_q;
  logic [7:0]    swd, srd_q;

  logic [3:0]    meff;
  logic [WW-1:0] clr, code_x, nfc_x, walk_x, grow_x;
  logic [23:0]   code_full;
  logic [NW-1:0] nfc_inc;
  logic          out_free, dict_full, stack_room;
  logic [7:0]    fc;
  logic [31:0]   byte_sh;
  logic [16:0]   col_n, r;
  logic [15:0]   h;
  logic [1:0]    p;
  logic          done;

  assign s_axis_tready = (state_q == glzw_pkg::StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tdata  = odata_q;

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      dict_mem[dwa] <= dwd;
    end
    if (dre) begin
      drd_q <= dict_mem[dra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (swe) begin
      stack_mem[swa] <= swd;
    end
    if (sre) begin
      srd_q <= stack_mem[sra];
    end
  end

  always_comb begin
    if (min_q < 4'd2) begin
      meff = 4'd2;
    end else if (min_q > 4'd8) begin
      meff = 4'd8;
    end else begin
      meff = min_q;
    end
  end

  assign clr        = WW'(1) << meff;
  assign code_full  = buf_q & ((24'd1 << cw_q) - 24'd1);
  assign code_x     = WW'(code_full);
  assign nfc_x      = WW'(nfc_q);
  assign walk_x     = WW'(walk_q);
  assign nfc_inc    = nfc_q + NW'(1);
  assign grow_x     = WW'(1) << cw_q;
  assign out_free   = !ovalid_q || m_axis_tready;
  assign dict_full  = (nfc_q == NW'(DICT_DEPTH));
  assign stack_room = (scnt_q != NW'(DICT_DEPTH));
  assign byte_sh    = {24'd0, s_axis_tdata} << bcnt_q;

  always_comb begin
    state_d  = state_q;
    min_d    = min_q;
    wid_d    = wid_q;
    hgt_d    = hgt_q;
    ilace_d  = ilace_q;
    cw_d     = cw_q;
    nfc_d    = nfc_q;
    pend_d   = pend_q;
    prev_d   = prev_q;
    pfirst_d = pfirst_q;
    code_d   = code_q;
    walk_d   = walk_q;
    scnt_d   = scnt_q;
    buf_d    = buf_q;
    bcnt_d   = bcnt_q;
    bbl_d    = bbl_q;
    col_d    = col_q;
    row_d    = row_q;
    ended_d  = ended_q;
    ovalid_d = m_axis_tready ? 1'b0 : ovalid_q;
    ostat_d  = ostat_q;
    odata_d  = odata_q;
    dwe = 1'b0;
    dre = 1'b0;
    swe = 1'b0;
    sre = 1'b0;
    dwa = nfc_q[AW-1:0];
    dra = walk_q;
    dwd = '0;
    swa = scnt_q[AW-1:0];
    sra = scnt_q[AW-1:0] - AW'(1);
    swd = '0;
    fc  = '0;
    col_n = {1'b0, col_q} + 17'd1;
    h     = (hgt_q == 16'd0) ? 16'd1 : hgt_q;
    r     = '0;
    p     = '0;
    done  = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        glzw_pkg::RegMinCode: begin
          min_d  = cfg_data_i[3:0];
          cw_d   = ((cfg_data_i[3:0] < 4'd2) ? 4'd2 :
                    (cfg_data_i[3:0] > 4'd8) ? 4'd8 : cfg_data_i[3:0]) + 4'd1;
          nfc_d  = NW'((WW'(1) << (cw_d - 4'd1)) + WW'(2));
          pend_d = 1'b1;
        end
        glzw_pkg::RegWidth:      wid_d   = cfg_data_i;
        glzw_pkg::RegHeight:     hgt_d   = cfg_data_i;
        glzw_pkg::RegInterlaced: ilace_d = cfg_data_i[0];
        default: ;
      endcase
    end

    unique case (state_q)
      glzw_pkg::StIdle: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == glzw_pkg::CmdTick) begin
            state_d = glzw_pkg::StCheck;
          end else if (!ended_q) begin
            if (bbl_q == 8'd0) begin
              bbl_d = s_axis_tdata;
            end else if (bcnt_q <= 5'd16) begin
              bbl_d  = bbl_q - 8'd1;
              buf_d  = buf_q | byte_sh[23:0];
              bcnt_d = bcnt_q + 5'd8;
            end
          end
        end
      end

      glzw_pkg::StCheck: begin
        if (out_free) begin
          if (ended_q) begin
            ovalid_d = 1'b1;
            ostat_d  = glzw_pkg::StatusEnded;
            odata_d  = '0;
            state_d  = glzw_pkg::StIdle;
          end else if (scnt_q != '0) begin
            sre     = 1'b1;
            scnt_d  = scnt_q - NW'(1);
            state_d = glzw_pkg::StPop;
          end else if (bcnt_q < 5'(cw_q)) begin
            ovalid_d = 1'b1;
            ostat_d  = glzw_pkg::StatusNeed;
            odata_d  = '0;
            state_d  = glzw_pkg::StIdle;
          end else begin
            buf_d  = buf_q >> cw_q;
            bcnt_d = bcnt_q - 5'(cw_q);
            if (code_x == clr) begin
              cw_d   = meff + 4'd1;
              nfc_d  = NW'(clr + WW'(2));
              pend_d = 1'b1;
            end else if (code_x == clr + WW'(1)) begin
              ended_d  = 1'b1;
              ovalid_d = 1'b1;
              ostat_d  = glzw_pkg::StatusEnded;
              odata_d  = '0;
              state_d  = glzw_pkg::StIdle;
            end else if (pend_q) begin
              if (code_x > clr) begin
                ovalid_d = 1'b1;
                ostat_d  = glzw_pkg::StatusInvalid;
                odata_d  = '0;
                state_d  = glzw_pkg::StIdle;
              end else begin
                pend_d   = 1'b0;
                prev_d   = AW'(code_x);
                pfirst_d = code_x[7:0];
                swe      = 1'b1;
                swd      = code_x[7:0];
                scnt_d   = scnt_q + NW'(1);
              end
            end else if (code_x > nfc_x || (code_x == nfc_x && dict_full)) begin
              ovalid_d = 1'b1;
              ostat_d  = glzw_pkg::StatusInvalid;
              odata_d  = '0;
              state_d  = glzw_pkg::StIdle;
            end else begin
              code_d  = code_x[CW-1:0];
              dre     = 1'b1;
              dra     = code_x[AW-1:0];
              state_d = glzw_pkg::StFirst;
            end
          end
        end
      end

      glzw_pkg::StPop: begin
        ovalid_d = 1'b1;
        ostat_d  = glzw_pkg::StatusPixel;
        odata_d  = {row_q, col_q, srd_q};
        state_d  = glzw_pkg::StIdle;
        if (col_n < {1'b0, wid_q}) begin
          col_d = col_n[15:0];
        end else begin
          col_d = '0;
          if (!ilace_q) begin
            r = {1'b0, row_q} + 17'd1;
            if (r >= {1'b0, h}) begin
              ended_d = 1'b1;
            end else begin
              row_d = r[15:0];
            end
          end else begin
            p = (row_q[2:0] == 3'd0) ? 2'd0 : (row_q[2:0] == 3'd4) ? 2'd1 :
                (!row_q[0]) ? 2'd2 : 2'd3;
            r = {1'b0, row_q} + 17'(glzw_pkg::pass_step(p));
            for (int i = 0; i < 4; i++) begin
              if (!done) begin
                if (r < {1'b0, h}) begin
                  row_d = r[15:0];
                  done  = 1'b1;
                end else if (p == 2'd3) begin
                  ended_d = 1'b1;
                  done    = 1'b1;
                end else begin
                  p = p + 2'd1;
                  r = 17'(glzw_pkg::pass_start(p));
                end
              end
            end
          end
        end
        if (ended_d) begin
          scnt_d = '0;
        end
      end

      glzw_pkg::StFirst: begin
        if (WW'(code_q) == nfc_x) begin
          fc = pfirst_q;
        end else if (WW'(code_q) < clr) begin
          fc = code_q[7:0];
        end else begin
          fc = drd_q.first;
        end
        if (!dict_full) begin
          dwe   = 1'b1;
          dwd   = '{prefix: prev_q, suffix: fc, first: pfirst_q};
          nfc_d = nfc_inc;
          if (cw_q < 4'(MAX_CODE_BITS) && WW'(nfc_inc) == grow_x) begin
            cw_d = cw_q + 4'd1;
          end
        end
        walk_d   = AW'(WW'(code_q));
        prev_d   = AW'(WW'(code_q));
        pfirst_d = fc;
        state_d  = glzw_pkg::StWalk;
      end

      glzw_pkg::StWalk: begin
        if (walk_x >= clr + WW'(2) && stack_room) begin
          dre     = 1'b1;
          state_d = glzw_pkg::StWalkD;
        end else begin
          if (stack_room) begin
            swe    = 1'b1;
            swd    = walk_q[7:0];
            scnt_d = scnt_q + NW'(1);
          end
          state_d = glzw_pkg::StCheck;
        end
      end

      glzw_pkg::StWalkD: begin
        swe     = 1'b1;
        swd     = drd_q.suffix;
        scnt_d  = scnt_q + NW'(1);
        walk_d  = drd_q.prefix;
        state_d = glzw_pkg::StWalk;
      end

      default: state_d = glzw_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= glzw_pkg::StIdle;
      min_q    <= 4'd8;
      wid_q    <= 16'd320;
      hgt_q    <= 16'd200;
      ilace_q  <= 1'b0;
      cw_q     <= 4'd9;
      nfc_q    <= NW'(258);
      pend_q   <= 1'b1;
      prev_q   <= '0;
      pfirst_q <= '0;
      scnt_q   <= '0;
      buf_q    <= '0;
      bcnt_q   <= '0;
      bbl_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      ended_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      min_q    <= min_d;
      wid_q    <= wid_d;
      hgt_q    <= hgt_d;
      ilace_q  <= ilace_d;
      cw_q     <= cw_d;
      nfc_q    <= nfc_d;
      pend_q   <= pend_d;
      prev_q   <= prev_d;
      pfirst_q <= pfirst_d;
      scnt_q   <= scnt_d;
      buf_q    <= buf_d;
      bcnt_q   <= bcnt_d;
      bbl_q    <= bbl_d;
      col_q    <= col_d;
      row_q    <= row_d;
      ended_q  <= ended_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    walk_q  <= walk_d;
    ostat_q <= ostat_d;
    odata_q <= odata_d;
  end

endmodule
